FILE: sv/mhpq_pkg.sv
// Shared types and constants for the min-heap priority queue.
// No dependencies; imported by mhpq_cell and min_heap_priority_queue.
package mhpq_pkg;

    localparam int CAPACITY = 128;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 8;
    localparam int STATUS_W = 2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [COUNT_W-1:0]      count_t;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
        key_t key;
    } cell_op_t;

endpackage

FILE: sv/mhpq_cell.sv
// One slot of the sorted key chain: holds a key, compares it with a pushed key,
// and shifts toward either neighbor. Depends on mhpq_pkg.
module mhpq_cell
    import mhpq_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  logic     occupied,
    input  logic     prev_lt,
    input  key_t     prev_val,
    input  key_t     next_val,
    output logic     lt,
    output key_t     val
);

    key_t val_reg;
    key_t val_next;

    // An empty slot sorts after every key; equal keys keep the older one first.
    assign lt  = !occupied || (op.key < val_reg);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (op.push)
        begin
            if (lt)
            begin
                val_next = prev_lt ? prev_val : op.key;
            end
        end
        else if (op.pop)
        begin
            val_next = next_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: sv/min_heap_priority_queue.sv
// Min-priority queue of signed keys kept as a sorted chain of cells.
// Depends on mhpq_pkg and mhpq_cell.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, mode, value           | into block
//   out     | out_valid, out_stall, popped_value,       | out of block
//           | status, entry_count                       |
//
// All cells compare against the pushed key in parallel and shift by one slot,
// so an item can enter every cycle while in_stall is low.
// Results wait in an output register; in_stall is high only while that
// register is full and out_stall holds it.
// Reset clears the entry count (count_reg) and the output valid; cell contents need none.
module min_heap_priority_queue
    import mhpq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                mode,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  popped_value,
    output logic [1:0]          status,
    output logic [7:0]          entry_count
);

    count_t               count_reg;
    count_t               count_next;
    logic                 out_valid_reg;
    key_t                 popped_reg;
    status_t              status_reg;
    status_t              status_next;
    key_t                 popped_next;
    count_t               out_count_reg;
    cell_op_t             op;
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 full;
    logic                 empty;
    logic [CAPACITY-1:0]  cell_lt;
    key_t                 cell_val [CAPACITY];

    assign in_stall = out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign full     = (count_reg == COUNT_W'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb
    begin
        op.push     = 1'b0;
        op.pop      = 1'b0;
        op.key      = value;
        count_next  = count_reg;
        status_next = ST_OK;
        popped_next = '0;
        if (in_xfer)
        begin
            case (mode_t'(mode))
                MODE_PUSH:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        op.push    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                MODE_POP:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        op.pop      = 1'b1;
                        popped_next = cell_val[0];
                        count_next  = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            key_t prev_val;
            key_t next_val;
            logic prev_lt;
            logic occupied;

            assign occupied = (COUNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_lt  = 1'b1;
                assign prev_val = value;
            end
            else
            begin : g_body
                assign prev_lt  = cell_lt[i-1];
                assign prev_val = cell_val[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_tail
                assign next_val = cell_val[i];
            end
            else
            begin : g_mid
                assign next_val = cell_val[i+1];
            end

            mhpq_cell u_cell (
                .clk      (clk),
                .op       (op),
                .occupied (occupied),
                .prev_lt  (prev_lt),
                .prev_val (prev_val),
                .next_val (next_val),
                .lt       (cell_lt[i]),
                .val      (cell_val[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_xfer)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result payload until it transfers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            popped_reg    <= popped_next;
            status_reg    <= status_next;
            out_count_reg <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign entry_count  = ENTRY_W'(out_count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode == MODE_PUSH && !full) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not add an entry");

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && mode == MODE_POP && !empty)
            |=> out_valid_reg && popped_reg == $past(cell_val[0]))
        else $error("pop did not return the head key");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= COUNT_W'(2)) |-> cell_val[0] <= cell_val[1])
        else $error("head key larger than its neighbor");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_EMPTY) |-> popped_reg == '0)
        else $error("empty pop returned a nonzero key");

endmodule
